/* hdl/mfb_pkg.sv */
// Shared constants and types for the monochrome frame store block.
// No dependencies; used by mfb_store, the top level and the checker.
package mfb_pkg;

    localparam int SCR_W       = 128;
    localparam int SCR_H       = 64;
    localparam int WORD_W      = 32;
    localparam int ROW_WORDS   = SCR_W / WORD_W;
    localparam int STORE_WORDS = SCR_H * ROW_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int ROW_W       = $clog2(SCR_H);
    localparam int KW          = $clog2(ROW_WORDS);
    localparam int COL_W       = $clog2(SCR_W);
    localparam int SHIFT_W     = $clog2(WORD_W);
    localparam int CRD_W       = 9;
    localparam int CELL_W      = 5;
    localparam int SCL_W       = 16;
    localparam int LINES_W     = 7;

    localparam int IN_DATA_W   = 56;
    localparam int PADDR_W     = 3;

    typedef enum logic [2:0] {
        M_CLEAR    = 3'd0,
        M_SCROLL   = 3'd1,
        M_INVERT   = 3'd2,
        M_CELL_CLR = 3'd3,
        M_READ     = 3'd4
    } t_mode;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_store_wr;

endpackage

/* hdl/mfb_store.sv */
// Pixel store: 256 x 32 synchronous RAM, one read and one write port.
// Per-word valid bits give all-zero contents after reset or a clear.
// Depends on mfb_pkg.
module mfb_store
    import mfb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data,
    input  t_store_wr         i_wr
);

    logic [WORD_W-1:0]      r_mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_valid;
    logic [WORD_W-1:0]      r_q;
    logic                   r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            r_qv <= r_valid[i_rd_addr];
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_qv ? r_q : '0;

endmodule

/* hdl/mono_framebuffer_raster_ops.sv */
// Monochrome 128x64 frame store with raster commands (top level).
// Depends on mfb_pkg and mfb_store.
//
// One command word in, one result word out. A command is taken only while
// the engine is idle; the result sits in an output register, so the next
// command can be taken while it waits. Clear goes straight to the result, a
// read waits for the registered store read, and scroll walks all 256 store
// words. Invert and cell clear pass a scale and a clip step, then walk each
// store word the clipped rectangle touches (rows x words-per-row-touched);
// a negative size ends at the scale step, an empty clip at clip. A result
// that finds the output register still full waits, and the engine takes no
// new command until it is passed on. The walk does one read-modify-write
// per cycle, set by the single store read port. The store reads as all
// zero after reset with no clearing pass.
module mono_framebuffer_raster_ops
    import mfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // pos_x, pos_y, area_width, area_height, scroll_lines, word_index
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    // mode
    input  logic [2:0]           i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // read_data
    output logic [WORD_W-1:0]    o_m_tdata,
    // command_done
    output logic                 o_m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_CLIP,
        S_WALK,
        S_RDWAIT,
        S_OUT
    } t_state;

    t_state             r_state;
    logic [2:0]         r_mode;
    logic [CRD_W-1:0]   r_px, r_py, r_aw, r_ah;
    logic [LINES_W-1:0] r_lines;
    logic [SCL_W-1:0]   r_x, r_y, r_w, r_h;
    logic [CELL_W-1:0]  r_cell_w, r_cell_h;
    logic [COL_W-1:0]   r_x0;
    logic [COL_W:0]     r_x1;
    logic [ROW_W-1:0]   r_row, r_row_hi;
    logic [KW-1:0]      r_k, r_k_lo, r_k_hi;
    logic [WORD_W-1:0]  r_mask;
    logic               r_zero;
    logic               r_wr_en;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [WORD_W-1:0]  r_res;

    logic               accept;
    logic [CRD_W-1:0]   in_px, in_py, in_aw, in_ah;
    logic [LINES_W-1:0] in_lines;
    logic [ADDR_W-1:0]  in_widx;
    logic               store_clear;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    t_store_wr          wr;
    logic [ROW_W+1:0]   src_sum;
    logic               n_zero;
    logic [WORD_W-1:0]  n_mask;
    logic               last_word;
    logic               out_free;
    logic signed [SCL_W:0] xe, ye, x0, x1, y0, y1;
    logic               clip_empty;
    logic [SCL_W:0]     x1m, y1m;

    assign accept   = i_s_tvalid && o_s_tready;
    assign in_px    = i_s_tdata[8:0];
    assign in_py    = i_s_tdata[17:9];
    assign in_aw    = i_s_tdata[26:18];
    assign in_ah    = i_s_tdata[35:27];
    assign in_lines = i_s_tdata[42:36];
    assign in_widx  = i_s_tdata[50:43];
    assign o_s_tready = (r_state == S_IDLE);
    assign out_free   = !o_m_tvalid || i_m_tready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {27'd0, r_cell_h} : {27'd0, r_cell_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w <= CELL_W'(4);
            r_cell_h <= CELL_W'(6);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_cell_h <= pwdata[CELL_W-1:0];
            else          r_cell_w <= pwdata[CELL_W-1:0];
        end
    end

    function automatic logic [WORD_W-1:0] span_mask(
        input logic [COL_W-1:0] lo_col,
        input logic [COL_W:0]   hi_col,
        input logic [KW-1:0]    k
    );
        logic signed [COL_W+1:0] lo, hi;
        logic [WORD_W-1:0]       m_lo, m_hi;
        lo = $signed({2'b00, lo_col}) - $signed({1'b0, k, {SHIFT_W{1'b0}}});
        hi = $signed({1'b0, hi_col}) - $signed({1'b0, k, {SHIFT_W{1'b0}}});
        if (lo < 0)                 m_lo = '1;
        else if (lo >= WORD_W)      m_lo = '0;
        else                        m_lo = '1 >> lo[SHIFT_W-1:0];
        if (hi <= 0)                m_hi = '1;
        else if (hi >= WORD_W)      m_hi = '0;
        else                        m_hi = '1 >> hi[SHIFT_W-1:0];
        return m_lo & ~m_hi;
    endfunction

    // clipping of the scaled rectangle
    always_comb begin
        xe  = $signed({r_x[SCL_W-1], r_x}) + $signed({r_w[SCL_W-1], r_w});
        ye  = $signed({r_y[SCL_W-1], r_y}) + $signed({r_h[SCL_W-1], r_h});
        x0  = r_x[SCL_W-1] ? '0 : $signed({1'b0, r_x});
        y0  = r_y[SCL_W-1] ? '0 : $signed({1'b0, r_y});
        x1  = (xe > SCR_W) ? (SCL_W+1)'(SCR_W) : xe;
        y1  = (ye > SCR_H) ? (SCL_W+1)'(SCR_H) : ye;
        clip_empty = (x0 >= x1) || (y0 >= y1);
        x1m = x1 - 1'b1;
        y1m = y1 - 1'b1;
    end

    // walk addressing
    always_comb begin
        src_sum   = {2'b00, r_row} + {1'b0, r_lines};
        n_zero    = (src_sum >= (ROW_W+2)'(SCR_H));
        n_mask    = span_mask(r_x0, r_x1, r_k);
        last_word = (r_k == r_k_hi) && (r_row == r_row_hi);
        if (r_state == S_IDLE)
            rd_addr = in_widx;
        else if (r_mode == M_SCROLL)
            rd_addr = {src_sum[ROW_W-1:0], r_k};
        else
            rd_addr = {r_row, r_k};
        store_clear = accept && (i_s_tuser == M_CLEAR);
    end

    always_comb begin
        wr.en   = r_wr_en;
        wr.addr = r_wr_addr;
        case (r_mode)
            M_INVERT:   wr.data = rd_data ^ r_mask;
            M_CELL_CLR: wr.data = rd_data & ~r_mask;
            default:    wr.data = r_zero ? '0 : rd_data;
        endcase
    end

    mfb_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (store_clear),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_en    <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else begin
            r_wr_en <= 1'b0;
            if (o_m_tvalid && i_m_tready && r_state != S_OUT) o_m_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_s_tuser;
                        r_px    <= in_px;
                        r_py    <= in_py;
                        r_aw    <= in_aw;
                        r_ah    <= in_ah;
                        r_lines <= in_lines;
                        r_res   <= '0;
                        r_row   <= '0;
                        r_k     <= '0;
                        r_k_lo  <= '0;
                        r_k_hi  <= '1;
                        r_row_hi <= '1;
                        case (i_s_tuser)
                            M_SCROLL:               r_state <= S_WALK;
                            M_INVERT, M_CELL_CLR:   r_state <= S_SCALE;
                            M_READ:                 r_state <= S_RDWAIT;
                            default:                r_state <= S_OUT;
                        endcase
                    end
                end
                S_SCALE: begin
                    if (r_aw[CRD_W-1] || r_ah[CRD_W-1]) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_mode == M_CELL_CLR) begin
                            r_x <= SCL_W'($signed({{(SCL_W-CRD_W){r_px[CRD_W-1]}}, r_px})
                                   * $signed({{(SCL_W-CELL_W){1'b0}}, r_cell_w}));
                            r_y <= SCL_W'($signed({{(SCL_W-CRD_W){r_py[CRD_W-1]}}, r_py})
                                   * $signed({{(SCL_W-CELL_W){1'b0}}, r_cell_h}));
                            r_w <= SCL_W'($signed({{(SCL_W-CRD_W){r_aw[CRD_W-1]}}, r_aw})
                                   * $signed({{(SCL_W-CELL_W){1'b0}}, r_cell_w}));
                            r_h <= SCL_W'($signed({{(SCL_W-CRD_W){r_ah[CRD_W-1]}}, r_ah})
                                   * $signed({{(SCL_W-CELL_W){1'b0}}, r_cell_h}));
                        end else begin
                            r_x <= {{(SCL_W-CRD_W){r_px[CRD_W-1]}}, r_px};
                            r_y <= {{(SCL_W-CRD_W){r_py[CRD_W-1]}}, r_py};
                            r_w <= {{(SCL_W-CRD_W){r_aw[CRD_W-1]}}, r_aw};
                            r_h <= {{(SCL_W-CRD_W){r_ah[CRD_W-1]}}, r_ah};
                        end
                        r_state <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    if (clip_empty) begin
                        r_state <= S_OUT;
                    end else begin
                        r_x0     <= x0[COL_W-1:0];
                        r_x1     <= x1[COL_W:0];
                        r_row    <= y0[ROW_W-1:0];
                        r_row_hi <= y1m[ROW_W-1:0];
                        r_k      <= x0[COL_W-1:SHIFT_W];
                        r_k_lo   <= x0[COL_W-1:SHIFT_W];
                        r_k_hi   <= x1m[COL_W-1:SHIFT_W];
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    r_wr_en   <= 1'b1;
                    r_wr_addr <= {r_row, r_k};
                    r_mask    <= n_mask;
                    r_zero    <= n_zero;
                    if (r_k == r_k_hi) begin
                        r_k   <= r_k_lo;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                    if (last_word) r_state <= S_OUT;
                end
                S_RDWAIT: begin
                    r_res   <= rd_data;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tdata  <= r_res;
                        o_m_tuser  <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/mfb_chk.sv */
// Port-level checker for mono_framebuffer_raster_ops, bound to the top.
// Depends on mfb_pkg.
module mfb_chk
    import mfb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic                 o_m_tuser
);

    // a held result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result word dropped while stalled");

    // every result word carries command_done
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser)
        else $error("result word without command_done");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command taken while busy");

    // no result straight out of reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word after reset");

    // a new result never appears in the cycle right after a command
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result word too early");

endmodule

bind mono_framebuffer_raster_ops mfb_chk u_mfb_chk (.*);

/* tb/mono_framebuffer_raster_ops_test.sv */
// Self-checking bench for mono_framebuffer_raster_ops: random raster commands, shadow store.
// Depends on mfb_pkg and the block's RTL; drives APB, and streams with random idling.
import mfb_pkg::*;

typedef struct packed {
    logic [2:0]        mode;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic signed [8:0] area_w;
    logic signed [8:0] area_h;
    logic [6:0]        lines;
    logic [7:0]        widx;
} t_raster_cmd;

typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              done;
} t_word_result;

class frame_checker;
    logic [WORD_W-1:0] shadow[STORE_WORDS];
    logic [CELL_W-1:0] cell_w;
    logic [CELL_W-1:0] cell_h;
    t_word_result      expected_words[$];
    int                mismatches;

    function new();
        foreach (shadow[i]) shadow[i] = '0;
        cell_w     = 5'd4;
        cell_h     = 5'd6;
        mismatches = 0;
    endfunction

    function void set_cell(int idx, logic [CELL_W-1:0] val);
        if (idx == 0) cell_w = val;
        else cell_h = val;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void apply_rect(int x, int y, int w, int h, bit flip);
        int x0, x1, y0, y1, idx;
        logic [WORD_W-1:0] mask;
        if (w < 0 || h < 0) return;
        x0 = (x < 0) ? 0 : x;
        x1 = x + w;
        if (x1 > SCR_W) x1 = SCR_W;
        if (x0 >= x1) return;
        y0 = (y < 0) ? 0 : y;
        y1 = y + h;
        if (y1 > SCR_H) y1 = SCR_H;
        if (y0 >= y1) return;
        for (int r = y0; r < y1; r++) begin
            for (int c = x0; c < x1; c++) begin
                idx  = r * ROW_WORDS + c / WORD_W;
                mask = 32'h8000_0000 >> (c % WORD_W);
                if (flip) shadow[idx] ^= mask;
                else shadow[idx] &= ~mask;
            end
        end
    endfunction

    function void note_command(logic [IN_DATA_W-1:0] td, logic [2:0] mode);
        int px, py, aw, ah, cw, ch, nl, dst;
        logic [7:0] widx;
        t_word_result r;
        px   = int'($signed(td[8:0]));
        py   = int'($signed(td[17:9]));
        aw   = int'($signed(td[26:18]));
        ah   = int'($signed(td[35:27]));
        nl   = int'(td[42:36]);
        widx = td[50:43];
        cw   = int'(cell_w);
        ch   = int'(cell_h);
        r.data = '0;
        r.done = 1'b1;
        case (mode)
            M_CLEAR: begin
                foreach (shadow[i]) shadow[i] = '0;
            end
            M_SCROLL: begin
                for (int row = 0; row < SCR_H; row++) begin
                    for (int k = 0; k < ROW_WORDS; k++) begin
                        dst = row * ROW_WORDS + k;
                        if (nl < SCR_H && row < SCR_H - nl)
                            shadow[dst] = shadow[(row + nl) * ROW_WORDS + k];
                        else
                            shadow[dst] = '0;
                    end
                end
            end
            M_INVERT: apply_rect(px, py, aw, ah, 1'b1);
            M_CELL_CLR: begin
                if (aw >= 0 && ah >= 0) apply_rect(px * cw, py * ch, aw * cw, ah * ch, 1'b0);
            end
            M_READ: r.data = shadow[widx];
            default: ;
        endcase
        expected_words.push_back(r);
    endfunction

    function void flag(string what, t_word_result exp, logic [WORD_W-1:0] data, logic done);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected data %h done %b, got data %h done %b",
                     what, exp.data, exp.done, data, done);
    endfunction

    function void check_word(logic [WORD_W-1:0] data, logic done);
        t_word_result exp;
        if (expected_words.size() == 0) begin
            exp = '0;
            flag("unexpected word", exp, data, done);
            return;
        end
        exp = expected_words.pop_front();
        if (data !== exp.data || done !== exp.done) flag("mismatch", exp, data, done);
    endfunction
endclass

module mono_framebuffer_raster_ops_test;

    localparam int          REG_CELL_W       = 0;
    localparam int          REG_CELL_H       = 1;
    localparam logic [2:0]  MODE_UNUSED_LO   = 3'd5;
    localparam logic [2:0]  MODE_UNUSED_HI   = 3'd7;
    localparam int          IDLE_LIMIT       = 5000;
    localparam int          DRAIN_CYCLES     = 300;
    localparam int          LONG_HOLD_AT     = 300;
    localparam int          LONG_HOLD_CYCLES = 1500;
    localparam int          RANDOM_ITEMS     = 1850;
    localparam int          N_PHASES         = 7;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic [2:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [WORD_W-1:0]    m_tdata;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    frame_checker fb_check = new();
    int           tx_run = 0;
    int           idle_cycles = 0;

    mono_framebuffer_raster_ops u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // results are checked before the same-edge command is noted
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) fb_check.check_word(m_tdata, m_tuser);
            if (s_tvalid && s_tready) fb_check.note_command(s_tdata, s_tuser);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic int draw_gap(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_cmd(t_raster_cmd c);
        return {5'b0, c.widx, c.lines, c.area_h, c.area_w, c.pos_y, c.pos_x};
    endfunction

    function automatic t_raster_cmd mk(logic [2:0] mode, int px, int py, int aw, int ah,
                                       int nl, int wi);
        t_raster_cmd c;
        c.mode   = mode;
        c.pos_x  = 9'(px);
        c.pos_y  = 9'(py);
        c.area_w = 9'(aw);
        c.area_h = 9'(ah);
        c.lines  = 7'(nl);
        c.widx   = 8'(wi);
        return c;
    endfunction

    function automatic t_raster_cmd rand_cmd();
        t_raster_cmd c;
        int pick;
        bit shaped;
        c.pos_x  = 9'($urandom);
        c.pos_y  = 9'($urandom);
        c.area_w = 9'($urandom);
        c.area_h = 9'($urandom);
        c.lines  = 7'($urandom);
        c.widx   = 8'($urandom);
        pick     = $urandom_range(0, 99);
        shaped   = ($urandom_range(0, 4) != 0);
        if (pick < 3) begin
            c.mode = M_CLEAR;
        end else if (pick < 11) begin
            c.mode = M_SCROLL;
            if (shaped) c.lines = 7'($urandom_range(0, SCR_H));
        end else if (pick < 40) begin
            c.mode = M_INVERT;
            if (shaped) begin
                c.pos_x  = 9'(int'($urandom_range(0, SCR_W + 15)) - 8);
                c.pos_y  = 9'(int'($urandom_range(0, SCR_H + 7)) - 4);
                c.area_w = 9'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 140)
                                                           : $urandom_range(0, 40));
                c.area_h = 9'($urandom_range(0, 24));
            end
        end else if (pick < 55) begin
            c.mode = M_CELL_CLR;
            if (shaped) begin
                c.pos_x  = 9'(int'($urandom_range(0, 43)) - 3);
                c.pos_y  = 9'(int'($urandom_range(0, 16)) - 2);
                c.area_w = 9'($urandom_range(0, 12));
                c.area_h = 9'($urandom_range(0, 6));
            end
        end else if (pick < 95) begin
            c.mode = M_READ;
        end else begin
            c.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        return c;
    endfunction

    task automatic send_cmd(input t_raster_cmd c);
        int gap;
        gap = draw_gap(tx_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cmd(c);
        s_tuser  <= c.mode;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // first wait for the clock so the command taken at the last edge is noted
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (fb_check.pending() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input int idx, input logic [CELL_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * idx);
        pwdata  <= {27'b0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        fb_check.set_cell(idx, val);
    endtask

    initial begin : result_sink
        int gap;
        int run;
        int taken;
        run   = 0;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            // one long hold-off so the block backs up and stalls its input
            gap = (taken == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_gap(run);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            taken++;
        end
    end

    initial begin : stimulus
        int cw_set[N_PHASES];
        int ch_set[N_PHASES];
        cw_set = '{4, 1, 16, 3, 31, 0, 5};
        ch_set = '{6, 1, 16, 9, 2, 7, 0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_INVERT, 0, 0, SCR_W, SCR_H, 0, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 255));
        send_cmd(mk(M_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_INVERT, -5, -3, 40, 10, 0, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_INVERT, 120, 60, 255, 255, 0, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 243));
        send_cmd(mk(M_INVERT, -256, -256, 255, 255, 0, 0));
        send_cmd(mk(M_INVERT, 255, 255, 255, 255, 0, 0));
        send_cmd(mk(M_INVERT, 10, 10, -1, 5, 0, 0));
        send_cmd(mk(M_INVERT, 10, 10, 6, 0, 0, 0));
        send_cmd(mk(M_INVERT, 30, 5, 5, 3, 0, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 21));
        send_cmd(mk(M_SCROLL, 0, 0, 0, 0, 1, 0));
        send_cmd(mk(M_CELL_CLR, 0, 0, 2, 1, 0, 0));
        send_cmd(mk(M_CELL_CLR, 0, 0, 3, -1, 0, 0));
        send_cmd(mk(M_SCROLL, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_SCROLL, 0, 0, 0, 0, 63, 0));
        send_cmd(mk(M_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(M_INVERT, 0, 0, SCR_W, SCR_H, 0, 0));
        send_cmd(mk(M_CELL_CLR, -2, -1, 40, 20, 0, 0));
        send_cmd(mk(M_INVERT, 0, 0, SCR_W, SCR_H, 0, 0));
        send_cmd(mk(M_SCROLL, 0, 0, 0, 0, 64, 0));
        send_cmd(mk(M_INVERT, 0, 0, SCR_W, SCR_H, 0, 0));
        send_cmd(mk(M_SCROLL, 0, 0, 0, 0, 127, 0));
        send_cmd(mk(MODE_UNUSED_LO, 0, 0, SCR_W, SCR_H, 0, 0));
        send_cmd(mk(MODE_UNUSED_HI, 0, 0, SCR_W, SCR_H, 0, 0));

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            cfg_write(REG_CELL_W, CELL_W'(cw_set[p]));
            cfg_write(REG_CELL_H, CELL_W'(ch_set[p]));
            for (int n = 0; n < RANDOM_ITEMS / N_PHASES; n++) send_cmd(rand_cmd());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fb_check.mismatches == 0 && fb_check.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* mono_framebuffer_raster_ops.f */
hdl/mfb_pkg.sv
hdl/mfb_store.sv
hdl/mono_framebuffer_raster_ops.sv
hdl/mfb_chk.sv
tb/mono_framebuffer_raster_ops_test.sv
